// ===== rtl/core/bfra_pkg.sv =====
// Shared types, codes and helpers for the best-fit range allocator.
package bfra_pkg;

    localparam int MAX_SLOTS   = 256;
    localparam int MAX_RANGES  = 128;
    localparam int STALE_DEPTH = 64;
    localparam int RIDX_W      = $clog2(MAX_RANGES);
    localparam int SIDX_W      = $clog2(STALE_DEPTH);

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_FREE    = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;

    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_FAIL = 2'd1;
    localparam logic [1:0] STS_FULL = 2'd2;

    localparam logic [1:0] REG_HEAP_SIZE   = 2'd0;
    localparam logic [1:0] REG_BASE_HANDLE = 2'd1;
    localparam logic [1:0] REG_HANDLE_INC  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_A_CHK, S_A_SCAN, S_A_UPD, S_A_ADD,
        S_F_DIV, S_F_WAIT, S_R_CHK, S_R_CMP, S_R_SCAN, S_R_UPD, S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic out_load;
        logic set_fail;
        logic scan_start;
        logic scan_step;
        logic alloc_commit;
        logic add_handle;
        logic div_start;
        logic free_commit;
        logic stale_rd;
        logic pop_start;
        logic ret_commit;
    } t_cmd;

    typedef struct packed {
        logic alloc_bad;
        logic scan_done;
        logic best_found;
        logic div_done;
        logic stale_empty;
        logic stale_due;
        logic out_free;
    } t_sts;

    // Slots in use, clamped to the table size.
    function automatic logic [8:0] live_of(input logic [8:0] size);
        live_of = (size > 9'(MAX_SLOTS)) ? 9'(MAX_SLOTS) : size;
    endfunction

endpackage

// ===== rtl/core/bfra_div.sv =====
// Restoring divider, one quotient bit per cycle, for handle-to-offset conversion.
module bfra_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [12:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    logic [31:0] r_q;
    logic [12:0] r_rem;
    logic [12:0] r_div;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [13:0] trial;
    logic        qbit;

    assign trial = {r_rem, r_q[31]};
    assign qbit  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[30:0], qbit};
            r_rem <= qbit ? 13'(trial - {1'b0, r_div}) : trial[12:0];
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

// ===== rtl/core/bfra_ctrl.sv =====
// Sequencer for allocate, free and release transactions.
module bfra_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_in_mode,
    input  bfra_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output bfra_pkg::t_cmd o_cmd
);
    import bfra_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_in_mode)
                        MODE_ALLOC:   n_state = S_A_CHK;
                        MODE_FREE:    n_state = S_F_DIV;
                        MODE_RELEASE: n_state = S_R_CHK;
                        default:      n_state = S_RESP;
                    endcase
                end
            end
            S_A_CHK: begin
                if (i_sts.alloc_bad) begin
                    o_cmd.set_fail = 1'b1;
                    n_state = S_RESP;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_A_SCAN;
                end
            end
            S_A_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) n_state = S_A_UPD;
            end
            S_A_UPD: begin
                if (i_sts.best_found) begin
                    o_cmd.alloc_commit = 1'b1;
                    n_state = S_A_ADD;
                end else begin
                    o_cmd.set_fail = 1'b1;
                    n_state = S_RESP;
                end
            end
            S_A_ADD: begin
                o_cmd.add_handle = 1'b1;
                n_state = S_RESP;
            end
            S_F_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = S_F_WAIT;
            end
            S_F_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.free_commit = 1'b1;
                    n_state = S_RESP;
                end
            end
            S_R_CHK: begin
                if (i_sts.stale_empty) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.stale_rd = 1'b1;
                    n_state = S_R_CMP;
                end
            end
            S_R_CMP: begin
                if (i_sts.stale_due) begin
                    o_cmd.pop_start  = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state = S_R_SCAN;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_R_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) n_state = S_R_UPD;
            end
            S_R_UPD: begin
                o_cmd.ret_commit = 1'b1;
                n_state = S_R_CHK;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== rtl/core/bfra_dp.sv =====
// Datapath: free-range table, stale queue, scan trackers and result register.
module bfra_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_addr,
    input  logic [63:0]    i_cfg_data,
    input  logic [8:0]     i_count,
    input  logic [63:0]    i_handle,
    input  logic [63:0]    i_frame,
    input  logic           i_out_ready,
    input  bfra_pkg::t_cmd i_cmd,
    output bfra_pkg::t_sts o_sts,
    output logic           o_out_valid,
    output logic [1:0]     o_status,
    output logic [63:0]    o_granted_handle,
    output logic [7:0]     o_granted_offset,
    output logic [8:0]     o_free_slots,
    output logic [6:0]     o_released_ranges
);
    import bfra_pkg::*;

    // configuration
    logic [8:0]  r_heap_size;
    logic [63:0] r_base;
    logic [12:0] r_inc;
    logic [8:0]  live;
    logic [8:0]  cfg_live;
    logic        cfg_heap;

    // latched transaction
    logic [8:0]  r_count;
    logic [63:0] r_handle;
    logic [63:0] r_frame;

    // running results
    logic [1:0]  r_status;
    logic [63:0] r_ghandle;
    logic [7:0]  r_goff;
    logic [6:0]  r_released;
    logic [8:0]  r_free;
    logic [20:0] r_prod;

    // range table
    logic [7:0]  mem_start [MAX_RANGES];
    logic [8:0]  mem_len   [MAX_RANGES];
    logic [MAX_RANGES-1:0] r_rvalid;
    logic        r_e0_init;
    logic        mem_we;
    logic [RIDX_W-1:0] mem_waddr;
    logic [7:0]  mem_wstart;
    logic [8:0]  mem_wlen;

    // scan pipeline
    logic [RIDX_W:0]   r_scan_idx;
    logic              r_pv;
    logic [RIDX_W-1:0] r_pidx;
    logic              r_pval;
    logic              r_pe0;
    logic [7:0]        r_rd_start;
    logic [8:0]        r_rd_len;
    logic [7:0]        e_start;
    logic [8:0]        e_len;
    logic [9:0]        e_end;

    // best fit tracker
    logic              r_bf;
    logic [RIDX_W-1:0] r_bidx;
    logic [7:0]        r_bstart;
    logic [8:0]        r_blen;
    logic              better;

    // return tracker
    logic [7:0]        r_off;
    logic [8:0]        r_len;
    logic [9:0]        ret_end;
    logic              r_ovl;
    logic              r_pf;
    logic [RIDX_W-1:0] r_pfidx;
    logic [7:0]        r_pfstart;
    logic [8:0]        r_pflen;
    logic              r_nf;
    logic [RIDX_W-1:0] r_nfidx;
    logic [8:0]        r_nflen;
    logic              r_ef;
    logic [RIDX_W-1:0] r_efidx;
    logic              ret_ok;

    // stale queue
    logic [7:0]        st_start [STALE_DEPTH];
    logic [8:0]        st_len   [STALE_DEPTH];
    logic [63:0]       st_frame [STALE_DEPTH];
    logic [SIDX_W-1:0] r_head;
    logic [SIDX_W:0]   r_fill;
    logic [7:0]        r_sq_start;
    logic [8:0]        r_sq_len;
    logic [63:0]       r_sq_frame;
    logic              st_we;
    logic [SIDX_W-1:0] st_waddr;

    // free path
    logic        div_done;
    logic [31:0] quot;
    logic [31:0] diff;
    logic [12:0] inc_eff;
    logic        free_bad;

    // output register
    logic        r_ovalid;
    logic [1:0]  r_o_status;
    logic [63:0] r_o_ghandle;
    logic [7:0]  r_o_goff;
    logic [8:0]  r_o_free;
    logic [6:0]  r_o_rel;

    assign live     = live_of(r_heap_size);
    assign cfg_live = live_of(i_cfg_data[8:0]);
    assign cfg_heap = i_cfg_we && (i_cfg_addr == REG_HEAP_SIZE);

    // ---------------- configuration registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_size <= 9'(MAX_SLOTS);
            r_base      <= '0;
            r_inc       <= 13'd32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_HEAP_SIZE:   r_heap_size <= i_cfg_data[8:0];
                REG_BASE_HANDLE: r_base      <= i_cfg_data;
                REG_HANDLE_INC:  r_inc       <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // ---------------- transaction latch ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_count  <= i_count;
            r_handle <= i_handle;
            r_frame  <= i_frame;
        end
    end

    // ---------------- range table ----------------
    assign e_start = r_pe0 ? 8'd0 : r_rd_start;
    assign e_len   = r_pe0 ? live : r_rd_len;
    assign e_end   = {2'b0, e_start} + {1'b0, e_len};
    assign ret_end = {2'b0, r_off} + {1'b0, r_len};
    assign ret_ok  = !r_ovl && (r_pf || r_nf || r_ef);

    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wstart = '0;
        mem_wlen   = '0;
        if (cfg_heap) begin
            mem_we   = 1'b1;
            mem_wlen = cfg_live;
        end else if (i_cmd.alloc_commit) begin
            mem_we     = 1'b1;
            mem_waddr  = r_bidx;
            mem_wstart = 8'(r_bstart + r_count[7:0]);
            mem_wlen   = r_blen - r_count;
        end else if (i_cmd.ret_commit && ret_ok) begin
            mem_we = 1'b1;
            if (r_pf) begin
                mem_waddr  = r_pfidx;
                mem_wstart = r_pfstart;
                mem_wlen   = r_pflen + r_len + (r_nf ? r_nflen : 9'd0);
            end else if (r_nf) begin
                mem_waddr  = r_nfidx;
                mem_wstart = r_off;
                mem_wlen   = r_nflen + r_len;
            end else begin
                mem_waddr  = r_efidx;
                mem_wstart = r_off;
                mem_wlen   = r_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_start[mem_waddr] <= mem_wstart;
            mem_len[mem_waddr]   <= mem_wlen;
        end
        if (i_cmd.scan_step && !r_scan_idx[RIDX_W]) begin
            r_rd_start <= mem_start[r_scan_idx[RIDX_W-1:0]];
            r_rd_len   <= mem_len[r_scan_idx[RIDX_W-1:0]];
        end
    end

    // valid bits; entry 0 reads its reset contents until first written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid  <= MAX_RANGES'(1);
            r_e0_init <= 1'b1;
        end else begin
            if (mem_we && mem_waddr == '0) r_e0_init <= 1'b0;
            if (cfg_heap) begin
                r_rvalid    <= '0;
                r_rvalid[0] <= (cfg_live != 9'd0);
            end else if (i_cmd.alloc_commit) begin
                if (r_blen == r_count) r_rvalid[r_bidx] <= 1'b0;
            end else if (i_cmd.ret_commit && ret_ok) begin
                if (r_pf) begin
                    if (r_nf) r_rvalid[r_nfidx] <= 1'b0;
                end else if (!r_nf) begin
                    r_rvalid[r_efidx] <= 1'b1;
                end
            end
        end
    end

    // ---------------- scan pipeline and trackers ----------------
    assign better = r_pval && (e_len >= r_count) &&
                    (!r_bf || e_len < r_blen || (e_len == r_blen && e_start < r_bstart));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv       <= 1'b0;
            r_scan_idx <= '0;
        end else if (i_cmd.scan_start) begin
            r_pv       <= 1'b0;
            r_scan_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_pv   <= !r_scan_idx[RIDX_W];
            r_pidx <= r_scan_idx[RIDX_W-1:0];
            r_pval <= r_rvalid[r_scan_idx[RIDX_W-1:0]];
            r_pe0  <= (r_scan_idx == '0) && r_e0_init;
            if (!r_scan_idx[RIDX_W]) r_scan_idx <= r_scan_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_bf  <= 1'b0;
            r_ovl <= 1'b0;
            r_pf  <= 1'b0;
            r_nf  <= 1'b0;
            r_ef  <= 1'b0;
        end else if (i_cmd.scan_step && r_pv) begin
            if (better) begin
                r_bf     <= 1'b1;
                r_bidx   <= r_pidx;
                r_bstart <= e_start;
                r_blen   <= e_len;
            end
            if (!r_pval) begin
                if (!r_ef) begin
                    r_ef    <= 1'b1;
                    r_efidx <= r_pidx;
                end
            end else begin
                if ({2'b0, e_start} < ret_end && {2'b0, r_off} < e_end) r_ovl <= 1'b1;
                if (e_end == {2'b0, r_off}) begin
                    r_pf      <= 1'b1;
                    r_pfidx   <= r_pidx;
                    r_pfstart <= e_start;
                    r_pflen   <= e_len;
                end
                if ({2'b0, e_start} == ret_end) begin
                    r_nf    <= 1'b1;
                    r_nfidx <= r_pidx;
                    r_nflen <= e_len;
                end
            end
        end
    end

    // ---------------- free path ----------------
    assign diff    = 32'(r_handle - r_base);
    assign inc_eff = (r_inc == 13'd0) ? 13'd1 : r_inc;

    bfra_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (diff),
        .i_divisor  (inc_eff),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    assign free_bad = (r_count == 9'd0) || (quot >= {23'd0, live}) ||
                      (r_count > 9'(live - quot[8:0]));
    assign st_we    = i_cmd.free_commit && !free_bad && !r_fill[SIDX_W];
    assign st_waddr = SIDX_W'(r_head + r_fill[SIDX_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            st_start[st_waddr] <= quot[7:0];
            st_len[st_waddr]   <= r_count;
            st_frame[st_waddr] <= r_frame;
        end
        if (i_cmd.stale_rd) begin
            r_sq_start <= st_start[r_head];
            r_sq_len   <= st_len[r_head];
            r_sq_frame <= st_frame[r_head];
        end
        if (i_cmd.pop_start) begin
            r_off <= r_sq_start;
            r_len <= r_sq_len;
        end
    end

    // ---------------- counters and results ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= 9'(MAX_SLOTS);
            r_head <= '0;
            r_fill <= '0;
        end else if (cfg_heap) begin
            r_free <= cfg_live;
            r_head <= '0;
            r_fill <= '0;
        end else begin
            if (i_cmd.alloc_commit) r_free <= r_free - r_count;
            if (i_cmd.ret_commit && ret_ok) r_free <= r_free + r_len;
            if (st_we) r_fill <= r_fill + 1'b1;
            if (i_cmd.pop_start) begin
                r_head <= r_head + 1'b1;
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status   <= STS_OK;
            r_ghandle  <= '0;
            r_goff     <= '0;
            r_released <= '0;
        end else begin
            if (i_cmd.set_fail) r_status <= STS_FAIL;
            if (i_cmd.alloc_commit) begin
                r_prod <= r_bstart * r_inc;
                r_goff <= r_bstart;
            end
            if (i_cmd.add_handle) r_ghandle <= r_base + {43'd0, r_prod};
            if (i_cmd.free_commit) begin
                if (free_bad)              r_status <= STS_FAIL;
                else if (r_fill[SIDX_W])   r_status <= STS_FULL;
            end
            if (i_cmd.ret_commit && ret_ok) r_released <= r_released + 7'd1;
        end
    end

    // hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_status  <= r_status;
            r_o_ghandle <= r_ghandle;
            r_o_goff    <= r_goff;
            r_o_free    <= r_free;
            r_o_rel     <= r_released;
        end
    end

    assign o_sts.alloc_bad   = (r_count == 9'd0) || (r_count > r_free);
    assign o_sts.scan_done   = r_pv && (r_pidx == RIDX_W'(MAX_RANGES - 1));
    assign o_sts.best_found  = r_bf;
    assign o_sts.div_done    = div_done;
    assign o_sts.stale_empty = (r_fill == '0);
    assign o_sts.stale_due   = (r_sq_frame <= r_frame);
    assign o_sts.out_free    = !r_ovalid || i_out_ready;

    assign o_out_valid       = r_ovalid;
    assign o_status          = r_o_status;
    assign o_granted_handle  = r_o_ghandle;
    assign o_granted_offset  = r_o_goff;
    assign o_free_slots      = r_o_free;
    assign o_released_ranges = r_o_rel;
endmodule

// ===== rtl/core/best_fit_range_allocator.sv =====
// Best-fit range allocator for a heap of descriptor slots (top level).
//
// Requests arrive on the s_axis channel, one result per request leaves on m_axis.
// Modes: allocate picks the smallest free range that fits (lowest start on ties),
// free converts a handle to a slot offset and queues it as stale with its frame,
// release returns stale ranges in queue order while their frame is at most the
// given frame, merging each with touching free ranges.
// Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_data while idle:
// index 0 heap size (clears table and stale queue), 1 base handle, 2 increment.
// Allocate time is set by the one-entry-per-cycle scan of the 128-entry range
// table through its single read port, free time by the bit-serial 32-bit divider;
// release time grows with each stale range popped, as every pop rescans the table.
// One request is in work at a time; s_axis_tready is high only between requests.
// A finished result sits in the output register; while m_axis_tready is low the
// block may still accept the next request, and holds that one's result until the
// register empties. Reset restores heap size 256, base 0, increment 32, one free
// range covering the heap and an empty stale queue; no clearing pass is needed.
module best_fit_range_allocator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_addr,
    input  logic [63:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // mode[1:0], count[10:2], handle[74:11], frame[138:75], zero pad
    input  logic [143:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // status[1:0], granted_handle[65:2], granted_offset[73:66], free_slots[82:74],
    // released_ranges[89:83], zero pad
    output logic [95:0]   m_axis_tdata
);
    import bfra_pkg::*;

    t_cmd        cmd;
    t_sts        sts;
    logic [1:0]  status;
    logic [63:0] ghandle;
    logic [7:0]  goff;
    logic [8:0]  free_slots;
    logic [6:0]  released;

    bfra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (s_axis_tdata[1:0]),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    bfra_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data),
        .i_count           (s_axis_tdata[10:2]),
        .i_handle          (s_axis_tdata[74:11]),
        .i_frame           (s_axis_tdata[138:75]),
        .i_out_ready       (m_axis_tready),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_out_valid       (m_axis_tvalid),
        .o_status          (status),
        .o_granted_handle  (ghandle),
        .o_granted_offset  (goff),
        .o_free_slots      (free_slots),
        .o_released_ranges (released)
    );

    assign m_axis_tdata = {6'd0, released, free_slots, goff, ghandle, status};

    // pad bits of the request carry nothing
    logic unused_pad;
    assign unused_pad = ^s_axis_tdata[143:139];
endmodule
